>>> src/mpq_pkg.sv
package mpq_pkg;

  localparam int NODE_W      = 7;
  localparam int NODES       = 128;
  localparam int WEIGHT_W    = 16;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 8;
  localparam int EDGE_DEPTH  = 1024;
  localparam int EDGE_AW     = 10;
  localparam int EDGE_CNT_W  = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_QUERY,
    OP_ANSWER
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                hit;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } edge_rec_t;

  // One spanning forest node: its parent, the weight of the link to it, and
  // the order in which the node joined the forest.
  typedef struct packed {
    logic                is_root;
    logic [NODE_W-1:0]   ord;
    logic [NODE_W-1:0]   par;
    logic [WEIGHT_W-1:0] pw;
  } tree_rec_t;

  localparam int EDGE_REC_W = $bits(edge_rec_t);
  localparam int TREE_REC_W = $bits(tree_rec_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_INIT,
    S_ROOTSEEK,
    S_SCAN,
    S_SCAN_END,
    S_WALK_INIT,
    S_CAP_X0,
    S_CAP_Y,
    S_CAP_X,
    S_STEP
  } back_state_t;

endpackage

>>> src/mpq_ram.sv
module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/mpq_queue.sv
module mpq_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mpq_pkg::cmd_t push_cmd,
  input  logic          pop,
  output mpq_pkg::cmd_t pop_cmd,
  output logic          empty,
  output logic          full
);

  mpq_pkg::cmd_t                       slots [mpq_pkg::QUEUE_DEPTH];
  logic [mpq_pkg::QUEUE_AW-1:0]        wr_ptr;
  logic [mpq_pkg::QUEUE_AW-1:0]        rd_ptr;
  logic [mpq_pkg::QUEUE_CNT_W-1:0]     fill;

  assign empty   = (fill == '0);
  assign full    = (fill == mpq_pkg::QUEUE_CNT_W'(mpq_pkg::QUEUE_DEPTH));
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> src/mpq_front.sv
module mpq_front (
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mpq_pkg::KIND_W-1:0]         kind,
  input  logic [mpq_pkg::NODE_W-1:0]         node_a,
  input  logic [mpq_pkg::NODE_W-1:0]         node_b,
  input  logic [mpq_pkg::WEIGHT_W-1:0]       weight,
  input  logic [mpq_pkg::COUNT_W-1:0]        node_count,
  input  logic                               q_full,
  output logic                               push,
  output mpq_pkg::cmd_t                      push_cmd
);

  logic a_ok;
  logic b_ok;
  logic keep;

  assign a_ok     = ({1'b0, node_a} < node_count);
  assign b_ok     = ({1'b0, node_b} < node_count);
  assign in_stall = q_full;

  // Requests whose outcome is already known here become trivial answers;
  // edges with an endpoint outside the graph and unknown kinds are dropped.
  always_comb begin
    push_cmd.node_a = node_a;
    push_cmd.node_b = node_b;
    push_cmd.weight = weight;
    push_cmd.hit    = 1'b0;
    push_cmd.op     = mpq_pkg::OP_CLEAR;
    keep            = 1'b0;
    case (kind)
      mpq_pkg::KIND_CLEAR: begin
        keep = 1'b1;
      end
      mpq_pkg::KIND_ADD: begin
        push_cmd.op = mpq_pkg::OP_ADD;
        keep        = a_ok && b_ok;
      end
      mpq_pkg::KIND_QUERY: begin
        keep = 1'b1;
        if (!(a_ok && b_ok)) begin
          push_cmd.op = mpq_pkg::OP_ANSWER;
        end else if (node_a == node_b) begin
          push_cmd.op  = mpq_pkg::OP_ANSWER;
          push_cmd.hit = 1'b1;
        end else begin
          push_cmd.op = mpq_pkg::OP_QUERY;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule

>>> src/mpq_back.sv
module mpq_back (
  input  logic                         clk,
  input  logic                         rst,
  input  mpq_pkg::cmd_t                cmd,
  input  logic                         cmd_valid,
  output logic                         pop,
  input  logic [mpq_pkg::COUNT_W-1:0]  node_count,
  input  logic                         cfg_we,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [mpq_pkg::WEIGHT_W-1:0] max_weight
);

  mpq_pkg::back_state_t state, state_next;

  logic [mpq_pkg::EDGE_CNT_W-1:0] edge_total;
  logic [mpq_pkg::EDGE_CNT_W-1:0] scan_idx;
  logic                           built;
  logic [mpq_pkg::NODES-1:0]      in_tree;
  logic [mpq_pkg::COUNT_W-1:0]    count;
  logic [mpq_pkg::COUNT_W-1:0]    root_ptr;
  logic                           pend;
  logic                           best_valid;
  logic [mpq_pkg::WEIGHT_W-1:0]   best_w;
  logic [mpq_pkg::NODE_W-1:0]     best_node;
  logic [mpq_pkg::NODE_W-1:0]     best_par;
  logic [mpq_pkg::NODE_W-1:0]     x;
  logic [mpq_pkg::NODE_W-1:0]     y;
  logic [mpq_pkg::WEIGHT_W-1:0]   mx;
  logic [mpq_pkg::WEIGHT_W-1:0]   my;
  mpq_pkg::tree_rec_t             rec_x;
  mpq_pkg::tree_rec_t             rec_y;

  logic                           edge_we;
  mpq_pkg::edge_rec_t             edge_wdata;
  mpq_pkg::edge_rec_t             edge_rd;
  logic                           tree_we;
  logic [mpq_pkg::NODE_W-1:0]     tree_waddr;
  mpq_pkg::tree_rec_t             tree_wdata;
  logic [mpq_pkg::NODE_W-1:0]     tree_raddr;
  mpq_pkg::tree_rec_t             tree_rd;

  logic root_ok;
  logic root_taken;
  logic scan_more;
  logic scan_done;
  logic cand_ok;
  logic move_x;
  logic dead_end;

  assign root_ok    = !root_ptr[mpq_pkg::COUNT_W-1] && (root_ptr < node_count);
  assign root_taken = in_tree[root_ptr[mpq_pkg::NODE_W-1:0]];
  assign scan_more  = (scan_idx != edge_total);
  assign scan_done  = !scan_more && !pend;
  assign cand_ok    = pend
                      && ({1'b0, edge_rd.node_a} < node_count)
                      && ({1'b0, edge_rd.node_b} < node_count)
                      && (in_tree[edge_rd.node_a] ^ in_tree[edge_rd.node_b])
                      && (!best_valid || (edge_rd.weight < best_w));
  assign move_x     = (rec_x.ord > rec_y.ord);
  assign dead_end   = move_x ? rec_x.is_root : rec_y.is_root;

  mpq_ram #(
    .WIDTH (mpq_pkg::EDGE_REC_W),
    .DEPTH (mpq_pkg::EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total[mpq_pkg::EDGE_AW-1:0]),
    .wdata (edge_wdata),
    .raddr (scan_idx[mpq_pkg::EDGE_AW-1:0]),
    .rdata (edge_rd)
  );

  mpq_ram #(
    .WIDTH (mpq_pkg::TREE_REC_W),
    .DEPTH (mpq_pkg::NODES)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      mpq_pkg::S_IDLE: begin
        if (pop && cmd.op == mpq_pkg::OP_QUERY) begin
          state_next = built ? mpq_pkg::S_WALK_INIT : mpq_pkg::S_BUILD_INIT;
        end
      end
      mpq_pkg::S_BUILD_INIT: state_next = mpq_pkg::S_ROOTSEEK;
      mpq_pkg::S_ROOTSEEK: begin
        if (!root_ok) begin
          state_next = mpq_pkg::S_WALK_INIT;
        end else if (!root_taken) begin
          state_next = mpq_pkg::S_SCAN;
        end
      end
      mpq_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = mpq_pkg::S_SCAN_END;
        end
      end
      mpq_pkg::S_SCAN_END: begin
        state_next = best_valid ? mpq_pkg::S_SCAN : mpq_pkg::S_ROOTSEEK;
      end
      mpq_pkg::S_WALK_INIT: state_next = mpq_pkg::S_CAP_X0;
      mpq_pkg::S_CAP_X0:    state_next = mpq_pkg::S_CAP_Y;
      mpq_pkg::S_CAP_Y:     state_next = mpq_pkg::S_STEP;
      mpq_pkg::S_CAP_X:     state_next = mpq_pkg::S_STEP;
      mpq_pkg::S_STEP: begin
        if (x == y || dead_end) begin
          state_next = mpq_pkg::S_IDLE;
        end else begin
          state_next = move_x ? mpq_pkg::S_CAP_X : mpq_pkg::S_CAP_Y;
        end
      end
      default: state_next = mpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop               = (state == mpq_pkg::S_IDLE) && cmd_valid && !out_valid;
    edge_we           = pop && (cmd.op == mpq_pkg::OP_ADD)
                        && (edge_total < mpq_pkg::EDGE_CNT_W'(mpq_pkg::EDGE_DEPTH));
    edge_wdata.node_a = cmd.node_a;
    edge_wdata.node_b = cmd.node_b;
    edge_wdata.weight = cmd.weight;
    tree_we           = 1'b0;
    tree_waddr        = best_node;
    tree_wdata.is_root = 1'b0;
    tree_wdata.ord    = count[mpq_pkg::NODE_W-1:0];
    tree_wdata.par    = best_par;
    tree_wdata.pw     = best_w;
    tree_raddr        = x;
    case (state)
      mpq_pkg::S_ROOTSEEK: begin
        tree_we            = root_ok && !root_taken;
        tree_waddr         = root_ptr[mpq_pkg::NODE_W-1:0];
        tree_wdata.is_root = 1'b1;
        tree_wdata.par     = root_ptr[mpq_pkg::NODE_W-1:0];
        tree_wdata.pw      = '0;
      end
      mpq_pkg::S_SCAN_END: tree_we = best_valid;
      mpq_pkg::S_CAP_X0:   tree_raddr = y;
      mpq_pkg::S_STEP:     tree_raddr = move_x ? rec_x.par : rec_y.par;
      default: tree_raddr = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mpq_pkg::S_IDLE;
      edge_total <= '0;
      built      <= 1'b0;
      in_tree    <= '0;
      pend       <= 1'b0;
      best_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        built <= 1'b0;
      end
      case (state)
        mpq_pkg::S_IDLE: begin
          if (pop) begin
            x <= cmd.node_a;
            y <= cmd.node_b;
            case (cmd.op)
              mpq_pkg::OP_CLEAR: begin
                edge_total <= '0;
                built      <= 1'b0;
              end
              mpq_pkg::OP_ADD: begin
                if (edge_we) begin
                  edge_total <= edge_total + 1'b1;
                  built      <= 1'b0;
                end
              end
              mpq_pkg::OP_ANSWER: begin
                out_valid  <= 1'b1;
                found      <= cmd.hit;
                max_weight <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        mpq_pkg::S_BUILD_INIT: begin
          in_tree  <= '0;
          count    <= '0;
          root_ptr <= '0;
        end
        mpq_pkg::S_ROOTSEEK: begin
          if (!root_ok) begin
            built <= 1'b1;
          end else if (root_taken) begin
            root_ptr <= root_ptr + 1'b1;
          end else begin
            in_tree[root_ptr[mpq_pkg::NODE_W-1:0]] <= 1'b1;
            count      <= count + 1'b1;
            scan_idx   <= '0;
            pend       <= 1'b0;
            best_valid <= 1'b0;
          end
        end
        mpq_pkg::S_SCAN: begin
          pend <= scan_more;
          if (scan_more) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (cand_ok) begin
            best_valid <= 1'b1;
            best_w     <= edge_rd.weight;
            if (in_tree[edge_rd.node_a]) begin
              best_node <= edge_rd.node_b;
              best_par  <= edge_rd.node_a;
            end else begin
              best_node <= edge_rd.node_a;
              best_par  <= edge_rd.node_b;
            end
          end
        end
        mpq_pkg::S_SCAN_END: begin
          if (best_valid) begin
            in_tree[best_node] <= 1'b1;
            count      <= count + 1'b1;
            scan_idx   <= '0;
            pend       <= 1'b0;
            best_valid <= 1'b0;
          end
        end
        mpq_pkg::S_WALK_INIT: begin
          mx <= '0;
          my <= '0;
        end
        mpq_pkg::S_CAP_X0: rec_x <= tree_rd;
        mpq_pkg::S_CAP_X:  rec_x <= tree_rd;
        mpq_pkg::S_CAP_Y:  rec_y <= tree_rd;
        mpq_pkg::S_STEP: begin
          if (x == y) begin
            out_valid  <= 1'b1;
            found      <= 1'b1;
            max_weight <= (mx > my) ? mx : my;
          end else if (dead_end) begin
            out_valid  <= 1'b1;
            found      <= 1'b0;
            max_weight <= '0;
          end else if (move_x) begin
            mx <= (rec_x.pw > mx) ? rec_x.pw : mx;
            x  <= rec_x.par;
          end else begin
            my <= (rec_y.pw > my) ? rec_y.pw : my;
            y  <= rec_y.par;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/minimax_path_query_engine.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+--------------------------------------
// request   | in_valid / in_stall    | kind, node_a, node_b, weight
// result    | out_valid / out_stall  | found, max_weight
// config    | cfg_we (no wait)       | cfg_wdata (node_count)
//
// Clear and add requests are handled in the back end's idle state. A query
// whose answer is known up front is answered there too; a tree walk reads one
// forest record per step through the single read port of the forest memory
// and takes at most one step fewer than the node limit. The first query after
// the graph or node_count changes first builds a spanning forest by Prim: one
// scan of the edge memory per added node.
// Reset is synchronous and active high; it empties the graph and sets
// node_count to 128. A four-entry queue lets requests arrive while the back
// end works or while a result waits under out_stall.
module minimax_path_query_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mpq_pkg::KIND_W-1:0]   kind,
  input  logic [mpq_pkg::NODE_W-1:0]   node_a,
  input  logic [mpq_pkg::NODE_W-1:0]   node_b,
  input  logic [mpq_pkg::WEIGHT_W-1:0] weight,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [mpq_pkg::WEIGHT_W-1:0] max_weight,
  input  logic                         cfg_we,
  input  logic [mpq_pkg::COUNT_W-1:0]  cfg_wdata
);

  // The node count register bounds both the classification in the front
  // end and the forest build in the back end.
  logic [mpq_pkg::COUNT_W-1:0] node_count;

  logic          push;
  mpq_pkg::cmd_t push_cmd;
  logic          pop;
  mpq_pkg::cmd_t pop_cmd;
  logic          q_empty;
  logic          q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= mpq_pkg::COUNT_W'(mpq_pkg::NODES);
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  // The front end sorts each request into work for the back end.
  mpq_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .node_a     (node_a),
    .node_b     (node_b),
    .weight     (weight),
    .node_count (node_count),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  mpq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end owns the edge and forest memories, builds the forest and
  // walks it from both query ends toward their common ancestor.
  mpq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (pop_cmd),
    .cmd_valid  (!q_empty),
    .pop        (pop),
    .node_count (node_count),
    .cfg_we     (cfg_we),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .max_weight (max_weight)
  );

`ifndef SYNTHESIS
  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("queue overrun");

  // The back end only takes work that exists.
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("queue underrun");

  // Work is taken only while the result register is free.
  assert property (@(posedge clk) disable iff (rst) pop |-> !out_valid)
    else $error("result overwritten");
`endif

endmodule
